>>> design/ccs_pkg.sv
// ccs_pkg: shared types and constants for the crank cadence sensor front end
package ccs_pkg;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NOTIFY   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLEEP    = 2'd2;

   localparam logic KIND_MEASURE = 1'b0;
   localparam logic KIND_SLEEP   = 1'b1;

   localparam logic [15:0] ROLL_MS = 16'd64000;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_START = 3'b010,
      PH_DONE  = 3'b100
   } phase_type;

   typedef struct packed {
      logic crank_level;
      logic link_up;
      logic subscribed;
   } req_word_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] revolutions;
      logic [15:0] event_time_1024;
   } rsp_word_type;

   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } rsp_slot_type;

endpackage

>>> design/ccs_in_stage.sv
// ccs_in_stage: input register for one tick word
module ccs_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ccs_pkg::req_word_type req_word,
   input  logic                  step,
   output logic                  item_valid,
   output ccs_pkg::req_word_type item_word
);

   logic                  valid_ff;
   logic                  valid_in;
   ccs_pkg::req_word_type word_ff;

   assign req_ready  = !valid_ff || step;
   assign item_valid = valid_ff;
   assign item_word  = word_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         word_ff <= req_word;
      end
   end

endmodule

>>> design/ccs_core.sv
// ccs_core: tick clock, reed debounce, report timer and sleep detection
module ccs_core (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write_en,
   input  logic [ccs_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [ccs_pkg::CSR_DATA_W-1:0]          csr_wdata,
   input  logic                                    step,
   input  ccs_pkg::req_word_type                   item_word,
   output ccs_pkg::rsp_slot_type                   result
);

   // floor(m * 1024 / 1000) for m below the roll period, via reciprocal of 125
   localparam logic [23:0] RECIP_125 = 24'd8589935;

   function automatic logic [15:0] scale_ms(input logic [15:0] m);
      logic [46:0] prod;
      begin
         prod     = {m, 7'd0} * RECIP_125;
         scale_ms = prod[45:30];
      end
   endfunction

   logic [9:0]  debounce_ff;
   logic [15:0] notify_ff;
   logic [23:0] sleep_ff;

   logic [31:0]        now_ff, now_in;
   logic [15:0]        now_mod_ff, now_mod_in;
   logic [15:0]        now_scaled_ff, now_scaled_in;
   ccs_pkg::phase_type phase_ff, phase_in;
   logic [31:0]        start_ff, start_in;
   logic [15:0]        rev_ff, rev_in;
   logic [31:0]        last_event_ff, last_event_in;
   logic [15:0]        event_scaled_ff, event_scaled_in;
   logic [31:0]        last_report_ff, last_report_in;
   logic               halted_ff, halted_in;

   logic low;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= 10'd10;
         notify_ff   <= 16'd1000;
         sleep_ff    <= 24'd60000;
      end else if (csr_write_en) begin
         case (csr_index)
            ccs_pkg::CSR_DEBOUNCE: debounce_ff <= csr_wdata[9:0];
            ccs_pkg::CSR_NOTIFY:   notify_ff   <= csr_wdata[15:0];
            ccs_pkg::CSR_SLEEP:    sleep_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign low = !item_word.crank_level;

   always_comb begin
      now_in          = now_ff;
      now_mod_in      = now_mod_ff;
      phase_in        = phase_ff;
      start_in        = start_ff;
      rev_in          = rev_ff;
      last_event_in   = last_event_ff;
      event_scaled_in = event_scaled_ff;
      last_report_in  = last_report_ff;
      halted_in       = halted_ff;
      result          = '0;

      if (step && !halted_ff) begin
         case (phase_ff)
            ccs_pkg::PH_START: begin
               if (!low) begin
                  phase_in = ccs_pkg::PH_IDLE;
               end else if ((now_ff - start_ff) > {22'd0, debounce_ff}) begin
                  phase_in        = ccs_pkg::PH_DONE;
                  rev_in          = rev_ff + 16'd1;
                  last_event_in   = now_ff;
                  event_scaled_in = now_scaled_ff;
               end
            end
            ccs_pkg::PH_DONE: begin
               if (!low) begin
                  phase_in = ccs_pkg::PH_IDLE;
               end
            end
            default: begin
               phase_in = ccs_pkg::PH_IDLE;
               if (low) begin
                  phase_in = ccs_pkg::PH_START;
                  start_in = now_ff;
               end
            end
         endcase

         now_in = now_ff + 32'd1;
         if (now_ff == 32'hFFFF_FFFF || now_mod_ff == ccs_pkg::ROLL_MS - 16'd1) begin
            now_mod_in = 16'd0;
         end else begin
            now_mod_in = now_mod_ff + 16'd1;
         end

         if (item_word.link_up) begin
            if ((now_ff - last_report_ff) > {16'd0, notify_ff}) begin
               last_report_in = now_ff;
               if (item_word.subscribed) begin
                  result.valid                = 1'b1;
                  result.word.kind            = ccs_pkg::KIND_MEASURE;
                  result.word.revolutions     = rev_in;
                  result.word.event_time_1024 = event_scaled_in;
               end
            end
         end else if ((now_ff - last_event_in) > {8'd0, sleep_ff}) begin
            result.valid     = 1'b1;
            result.word.kind = ccs_pkg::KIND_SLEEP;
            halted_in        = 1'b1;
            now_in           = now_ff;
            now_mod_in       = now_mod_ff;
         end
      end
   end

   assign now_scaled_in = scale_ms(now_mod_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff          <= '0;
         now_mod_ff      <= '0;
         now_scaled_ff   <= '0;
         phase_ff        <= ccs_pkg::PH_IDLE;
         start_ff        <= '0;
         rev_ff          <= '0;
         last_event_ff   <= '0;
         event_scaled_ff <= '0;
         last_report_ff  <= '0;
         halted_ff       <= 1'b0;
      end else begin
         now_ff          <= now_in;
         now_mod_ff      <= now_mod_in;
         now_scaled_ff   <= now_scaled_in;
         phase_ff        <= phase_in;
         start_ff        <= start_in;
         rev_ff          <= rev_in;
         last_event_ff   <= last_event_in;
         event_scaled_ff <= event_scaled_in;
         last_report_ff  <= last_report_in;
         halted_ff       <= halted_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) halted_ff |=> halted_ff)
      else $error("halt released without reset");

   assert property (@(posedge clock) disable iff (reset)
      (result.valid && result.word.kind == ccs_pkg::KIND_SLEEP) |=> halted_ff)
      else $error("sleep request did not halt");

   assert property (@(posedge clock) disable iff (reset) now_mod_ff < ccs_pkg::ROLL_MS)
      else $error("rolling millisecond count out of range");

   assert property (@(posedge clock) disable iff (reset) !step |=> $stable(rev_ff))
      else $error("revolution count moved without a tick");

endmodule

>>> design/ccs_out_stage.sv
// ccs_out_stage: result register towards the response channel
module ccs_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  ccs_pkg::rsp_slot_type result,
   output logic                  space,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ccs_pkg::rsp_word_type rsp_word
);

   logic                  valid_ff;
   logic                  valid_in;
   ccs_pkg::rsp_word_type word_ff;

   assign space     = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

   always_comb begin
      valid_in = valid_ff;
      if (space) begin
         valid_in = result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (space && result.valid) begin
         word_ff <= result.word;
      end
   end

endmodule

>>> design/crank_cadence_sensor_front_end.sv
// crank_cadence_sensor_front_end: reed debounce and cadence counter, top level
//
//   port group  direction  handshake            word
//   req_        in         req_valid/req_ready  crank_level, link_up, subscribed
//   rsp_        out        rsp_valid/rsp_ready  kind, revolutions, event_time_1024
//   csr_        in         csr_write_en         csr_index, csr_wdata
//
// one tick word per cycle unless the response stalls
// input register, combinational update of tick state, result register
// synchronous reset restores register defaults and clears all tick state
// a stalled response holds the update stage; an empty input register takes one word
// after a sleep request every further word is taken and dropped until reset
module crank_cadence_sensor_front_end (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_crank_level,
   input  logic                                req_link_up,
   input  logic                                req_subscribed,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_kind,
   output logic [15:0]                         rsp_revolutions,
   output logic [15:0]                         rsp_event_time_1024,
   input  logic                                csr_write_en,
   input  logic [ccs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ccs_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   ccs_pkg::req_word_type req_word;
   ccs_pkg::req_word_type item_word;
   ccs_pkg::rsp_word_type rsp_word;
   ccs_pkg::rsp_slot_type result;
   logic                  item_valid;
   logic                  space;
   logic                  step;

   assign req_word.crank_level = req_crank_level;
   assign req_word.link_up     = req_link_up;
   assign req_word.subscribed  = req_subscribed;

   assign step = item_valid && space;

   ccs_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .step       (step),
      .item_valid (item_valid),
      .item_word  (item_word)
   );

   ccs_core u_core (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .step         (step),
      .item_word    (item_word),
      .result       (result)
   );

   ccs_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   assign rsp_kind            = rsp_word.kind;
   assign rsp_revolutions     = rsp_word.revolutions;
   assign rsp_event_time_1024 = rsp_word.event_time_1024;

endmodule
